// ===== rtl/core/csfd_pkg.sv =====
// csfd_pkg: request types and decode constants for the status frame decoder
// no dependencies; used by coprocessor_status_frame_decoder_core

package csfd_pkg;

  // input request: one received byte
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } in_t;

  // result request: one decoded frame
  typedef struct packed {
    logic        frame_ok;
    logic [15:0] adc_zero;
    logic [15:0] adc_one;
    logic [15:0] adc_two;
    logic [15:0] adc_three;
    logic [3:0]  button_code;
    logic        aa_cells;
    logic [1:0]  fw_major;
    logic [2:0]  fw_minor;
    logic [13:0] supply_mv;
  } out_t;

  // reported converter ports
  localparam int NUM_ADC = 4;

  // checksum
  localparam logic [7:0] SUM_GOOD = 8'hFF;

  // button ladder
  localparam logic [15:0] BTN_ENTER_LIMIT  = 16'd1023;
  localparam logic [15:0] BTN_ENTER_OFFSET = 16'h07FF;
  localparam logic [15:0] BTN_THR_HIGH     = 16'd720;
  localparam logic [15:0] BTN_THR_MID      = 16'd270;
  localparam logic [15:0] BTN_THR_LOW      = 16'd60;
  localparam logic [3:0]  BTN_ENTER        = 4'h1;
  localparam logic [3:0]  BTN_HIGH         = 4'h8;
  localparam logic [3:0]  BTN_MID          = 4'h4;
  localparam logic [3:0]  BTN_LOW          = 4'h2;

  // battery word
  localparam logic [23:0] MV_SCALE = 24'd14180;
  localparam int          MV_FRAC  = 10;

endpackage

// ===== rtl/core/coprocessor_status_frame_decoder_core.sv =====
// coprocessor_status_frame_decoder_core: byte-wise status frame decoder
// result registered: valid in the cycle after the final byte of a frame is accepted
// throughput: one byte per cycle; one result per frame of 2*SENSOR_COUNT+5 bytes
// the final byte is held off only while the previous result is still stalled
// reset (rst_n low, synchronous): position, sum, held values and out_valid cleared
// depends on csfd_pkg

module coprocessor_status_frame_decoder_core #(
  parameter int SENSOR_COUNT = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  csfd_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output csfd_pkg::out_t  out_data
);

  // frame geometry: adc words, button word, battery word, trailing byte
  localparam int FRAME_LEN = 2 * SENSOR_COUNT + 5;
  localparam int STORE_LEN = 2 * SENSOR_COUNT + 4;
  localparam int LAST_POS  = FRAME_LEN - 1;
  localparam int POS_W     = $clog2(FRAME_LEN);
  localparam int BTN_POS   = 2 * SENSOR_COUNT;
  localparam int BAT_POS   = 2 * SENSOR_COUNT + 2;

  // byte tracking state
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [7:0]       store_r [STORE_LEN];

  // held decoded values, reported again on a bad frame
  logic [15:0] held_adc_r [csfd_pkg::NUM_ADC];
  logic [3:0]  held_code_r;
  logic        held_aa_r;
  logic [1:0]  held_major_r;
  logic [2:0]  held_minor_r;
  logic [13:0] held_mv_r;

  // result register
  logic           out_valid_r, out_valid_nxt;
  csfd_pkg::out_t out_r;

  logic [POS_W-1:0] eff_pos;
  logic [7:0]       eff_sum;
  logic             in_fire;
  logic             is_last;
  logic             frame_good;
  logic             load_result;

  // decoded fields of the frame now in the store
  logic [15:0] new_adc [csfd_pkg::NUM_ADC];
  logic [15:0] btn_word;
  logic [15:0] btn_adj;
  logic [15:0] bat_word;
  logic [3:0]  new_code;
  logic [23:0] mv_prod;
  logic [13:0] new_mv;

  // a start flag restarts position and sum before the byte is counted
  assign eff_pos = in_data.frame_start ? '0 : pos_r;
  assign eff_sum = in_data.frame_start ? '0 : sum_r;
  assign sum_nxt = eff_sum + in_data.rx_byte;
  assign is_last = (eff_pos == POS_W'(LAST_POS));

  // only a byte that may close a frame waits for the result slot
  assign in_stall    = out_valid_r && out_stall && (pos_r == POS_W'(LAST_POS));
  assign in_fire     = in_valid && !in_stall;
  assign load_result = in_fire && is_last;
  assign frame_good  = (sum_nxt == csfd_pkg::SUM_GOOD);

  // after the final byte the next frame starts at position zero
  always_comb begin
    pos_nxt = pos_r;
    if (in_fire) begin
      pos_nxt = is_last ? '0 : eff_pos + POS_W'(1);
    end
  end

  // little-endian adc words; ports beyond the sensor count read as zero
  for (genvar i = 0; i < csfd_pkg::NUM_ADC; i++) begin : g_adc
    if (i < SENSOR_COUNT) begin : g_present
      assign new_adc[i] = {store_r[2*i+1], store_r[2*i]};
    end else begin : g_absent
      assign new_adc[i] = '0;
    end
  end

  assign btn_word = {store_r[BTN_POS+1], store_r[BTN_POS]};
  assign bat_word = {store_r[BAT_POS+1], store_r[BAT_POS]};

  // button ladder: enter bit strips its offset, then one rung of three
  always_comb begin
    new_code = '0;
    btn_adj  = btn_word;
    if (btn_word > csfd_pkg::BTN_ENTER_LIMIT) begin
      new_code = csfd_pkg::BTN_ENTER;
      btn_adj  = btn_word - csfd_pkg::BTN_ENTER_OFFSET;
    end
    if (btn_adj > csfd_pkg::BTN_THR_HIGH) begin
      new_code = new_code | csfd_pkg::BTN_HIGH;
    end else if (btn_adj > csfd_pkg::BTN_THR_MID) begin
      new_code = new_code | csfd_pkg::BTN_MID;
    end else if (btn_adj > csfd_pkg::BTN_THR_LOW) begin
      new_code = new_code | csfd_pkg::BTN_LOW;
    end
  end

  // millivolts from the low ten bits of the battery word
  assign mv_prod = 24'(bat_word[9:0]) * csfd_pkg::MV_SCALE;
  assign new_mv  = mv_prod[csfd_pkg::MV_FRAC +: 14];

  // result slot empties when taken, fills on the final byte
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_result) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control and held state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      sum_r        <= '0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < csfd_pkg::NUM_ADC; i++) begin
        held_adc_r[i] <= '0;
      end
      held_code_r  <= '0;
      held_aa_r    <= 1'b0;
      held_major_r <= '0;
      held_minor_r <= '0;
      held_mv_r    <= '0;
    end else begin
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        sum_r <= is_last ? '0 : sum_nxt;
      end
      if (load_result && frame_good) begin
        for (int i = 0; i < csfd_pkg::NUM_ADC; i++) begin
          held_adc_r[i] <= new_adc[i];
        end
        held_code_r  <= new_code;
        held_aa_r    <= bat_word[15];
        held_major_r <= bat_word[14:13];
        held_minor_r <= bat_word[12:10];
        held_mv_r    <= new_mv;
      end
    end
  end

  // frame bytes, written at their position; the trailing byte is not kept
  always_ff @(posedge clk) begin
    for (int j = 0; j < STORE_LEN; j++) begin
      if (in_fire && (eff_pos == POS_W'(j))) begin
        store_r[j] <= in_data.rx_byte;
      end
    end
  end

  // result payload: fresh values on a good frame, held ones otherwise
  always_ff @(posedge clk) begin
    if (load_result) begin
      out_r.frame_ok    <= frame_good;
      out_r.adc_zero    <= frame_good ? new_adc[0]      : held_adc_r[0];
      out_r.adc_one     <= frame_good ? new_adc[1]      : held_adc_r[1];
      out_r.adc_two     <= frame_good ? new_adc[2]      : held_adc_r[2];
      out_r.adc_three   <= frame_good ? new_adc[3]      : held_adc_r[3];
      out_r.button_code <= frame_good ? new_code        : held_code_r;
      out_r.aa_cells    <= frame_good ? bat_word[15]    : held_aa_r;
      out_r.fw_major    <= frame_good ? bat_word[14:13] : held_major_r;
      out_r.fw_minor    <= frame_good ? bat_word[12:10] : held_minor_r;
      out_r.supply_mv   <= frame_good ? new_mv          : held_mv_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  // closing byte of a frame always produces a result next cycle
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    load_result |=> out_valid_r)
    else $error("final byte accepted without a result");

  // a waiting result always matches the held values
  a_result_matches_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.adc_zero == held_adc_r[0]) &&
                    (out_r.button_code == held_code_r) &&
                    (out_r.supply_mv == held_mv_r))
    else $error("result differs from held values");

  // position never runs past the final byte
  a_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_W'(LAST_POS))
    else $error("byte position beyond frame length");
`endif

endmodule
